// File: rtl/dpodc_pkg.sv
`default_nettype none

package dpodc_pkg;

    localparam int YEAR_MAX_DEF  = 9999;
    localparam int DAY_W         = 5;
    localparam int MON_W         = 4;
    localparam int YEAR_W        = 14;
    localparam int CNT_W         = 22;
    localparam int P365_W        = 23;
    localparam int PROD_W        = 27;
    localparam int QUO_W         = 8;
    localparam int DBM_W         = 9;
    localparam int RECIP_100     = 5243;
    localparam int RECIP_SH      = 19;
    localparam int DAYS_PER_YEAR = 365;
    localparam int CENTURY       = 100;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [MON_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MON_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MON_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
    } t_date;

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [DBM_W-1:0] days_before(input logic [MON_W-1:0] m);
        logic [DBM_W-1:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dpodc_day_num.sv
`default_nettype none

module dpodc_day_num #(
    parameter int YEAR_MAX = dpodc_pkg::YEAR_MAX_DEF,
    parameter int SERIAL_W = 22
) (
    input  wire logic                 i_clk,
    input  dpodc_pkg::t_date          i_date,
    output logic [SERIAL_W-1:0]       o_serial,
    output logic                      o_ok
);
    import dpodc_pkg::*;

    logic [YEAR_W-1:0]   w_p;
    logic [PROD_W-1:0]   w_pq;
    logic [PROD_W-1:0]   w_yq;
    logic [P365_W-1:0]   w_p365;
    logic                w_rng_ok;

    t_date               r1_date;
    logic [YEAR_W-1:0]   r1_p;
    logic [QUO_W-1:0]    r1_qp;
    logic [QUO_W-1:0]    r1_qy;
    logic [P365_W-1:0]   r1_p365;
    logic                r1_ok;

    logic [SERIAL_W-1:0] w_base;
    logic [YEAR_W:0]     w_y100;
    logic                w_leap;

    t_date               r2_date;
    logic [SERIAL_W-1:0] r2_base;
    logic                r2_leap;
    logic                r2_ok;

    logic [DAY_W-1:0]    w_len;
    logic                w_adj;
    logic [SERIAL_W-1:0] n_serial;
    logic [SERIAL_W-1:0] r_serial;
    logic                r_ok;

    // stage 1: year minus one, reciprocal products for the century quotients
    always_comb begin
        w_p      = i_date.year - YEAR_W'(1);
        w_pq     = PROD_W'(w_p) * PROD_W'(RECIP_100);
        w_yq     = PROD_W'(i_date.year) * PROD_W'(RECIP_100);
        w_p365   = P365_W'(w_p) * P365_W'(DAYS_PER_YEAR);
        w_rng_ok = (i_date.month >= MONTH_JAN) && (i_date.month <= MONTH_DEC)
                && (i_date.year != '0) && (32'(i_date.year) <= 32'(YEAR_MAX))
                && (i_date.day != '0);
    end

    always_ff @(posedge i_clk) begin
        r1_date <= i_date;
        r1_p    <= w_p;
        r1_qp   <= w_pq[RECIP_SH +: QUO_W];
        r1_qy   <= w_yq[RECIP_SH +: QUO_W];
        r1_p365 <= w_p365;
        r1_ok   <= w_rng_ok;
    end

    // stage 2: days before the year, leap test
    always_comb begin
        w_base = SERIAL_W'(r1_p365) + SERIAL_W'(r1_p >> 2)
               - SERIAL_W'(r1_qp) + SERIAL_W'(r1_qp >> 2);
        w_y100 = (YEAR_W+1)'(r1_qy) * (YEAR_W+1)'(CENTURY);
        w_leap = (r1_date.year[1:0] == 2'd0)
              && (({1'b0, r1_date.year} != w_y100) || (r1_qy[1:0] == 2'd0));
    end

    always_ff @(posedge i_clk) begin
        r2_date <= r1_date;
        r2_base <= w_base;
        r2_leap <= w_leap;
        r2_ok   <= r1_ok;
    end

    // stage 3: add month offset and day, check day against month length
    always_comb begin
        w_len    = month_len(r2_date.month, r2_leap);
        w_adj    = r2_leap && (r2_date.month > MONTH_FEB);
        n_serial = r2_base + SERIAL_W'(days_before(r2_date.month))
                 + SERIAL_W'(w_adj) + SERIAL_W'(r2_date.day);
    end

    always_ff @(posedge i_clk) begin
        r_serial <= n_serial;
        r_ok     <= r2_ok && (r2_date.day <= w_len);
    end

    assign o_serial = r_serial;
    assign o_ok     = r_ok;

endmodule

`default_nettype wire

// File: rtl/date_period_overlap_day_counter_unit.sv
// Each beat passes the three day-number stages, the intersect stage and the output stage,
// and its result then shows on o_valid.
// Throughput: one beat per cycle; o_busy is tied low in the five-stage pipeline.
// The receiver cannot stall; results are never held back.
// Reset (synchronous, active low) clears all valid bits; payload registers are not reset.
`default_nettype none

module date_period_overlap_day_counter_unit #(
    parameter int YEAR_MAX = dpodc_pkg::YEAR_MAX_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic [dpodc_pkg::DAY_W-1:0]   i_p1_start_day,
    input  wire logic [dpodc_pkg::MON_W-1:0]   i_p1_start_month,
    input  wire logic [dpodc_pkg::YEAR_W-1:0]  i_p1_start_year,
    input  wire logic [dpodc_pkg::DAY_W-1:0]   i_p1_end_day,
    input  wire logic [dpodc_pkg::MON_W-1:0]   i_p1_end_month,
    input  wire logic [dpodc_pkg::YEAR_W-1:0]  i_p1_end_year,
    input  wire logic [dpodc_pkg::DAY_W-1:0]   i_p2_start_day,
    input  wire logic [dpodc_pkg::MON_W-1:0]   i_p2_start_month,
    input  wire logic [dpodc_pkg::YEAR_W-1:0]  i_p2_start_year,
    input  wire logic [dpodc_pkg::DAY_W-1:0]   i_p2_end_day,
    input  wire logic [dpodc_pkg::MON_W-1:0]   i_p2_end_month,
    input  wire logic [dpodc_pkg::YEAR_W-1:0]  i_p2_end_year,
    output logic                               o_valid,
    output logic [dpodc_pkg::CNT_W-1:0]        o_overlap_days,
    output logic                               o_bad_date
);
    import dpodc_pkg::*;

    localparam int SERIAL_W = $clog2(YEAR_MAX * 366 + 32);
    localparam int DIFF_W   = SERIAL_W + 1;
    localparam int WIDE_W   = (DIFF_W > CNT_W) ? DIFF_W : CNT_W;
    localparam int NDATE    = 4;

    t_date               w_date [NDATE];
    logic [SERIAL_W-1:0] w_serial [NDATE];
    logic [NDATE-1:0]    w_ok;

    logic                w_accept;
    logic [3:0]          r_vld;

    logic [DIFF_W-1:0]   w_s1;
    logic [DIFF_W-1:0]   w_e1;
    logic [DIFF_W-1:0]   w_s2;
    logic [DIFF_W-1:0]   w_e2x;
    logic [DIFF_W-1:0]   r4_lo;
    logic [DIFF_W-1:0]   r4_hi;
    logic                r4_ok;

    logic [DIFF_W-1:0]   w_diff;
    logic [WIDE_W-1:0]   w_diff_wide;
    logic [CNT_W-1:0]    w_sat;
    logic [CNT_W-1:0]    n_days;

    logic                r_valid;
    logic [CNT_W-1:0]    r_days;
    logic                r_bad;

    assign w_accept = i_start && !o_busy;
    assign o_busy   = 1'b0;

    always_comb begin
        w_date[0] = '{day: i_p1_start_day, month: i_p1_start_month, year: i_p1_start_year};
        w_date[1] = '{day: i_p1_end_day,   month: i_p1_end_month,   year: i_p1_end_year};
        w_date[2] = '{day: i_p2_start_day, month: i_p2_start_month, year: i_p2_start_year};
        w_date[3] = '{day: i_p2_end_day,   month: i_p2_end_month,   year: i_p2_end_year};
    end

    for (genvar g = 0; g < NDATE; g++) begin : g_day
        dpodc_day_num #(
            .YEAR_MAX (YEAR_MAX),
            .SERIAL_W (SERIAL_W)
        ) u_day_num (
            .i_clk    (i_clk),
            .i_date   (w_date[g]),
            .o_serial (w_serial[g]),
            .o_ok     (w_ok[g])
        );
    end

    // stage 4: intersect the two ranges
    always_comb begin
        w_s1  = {1'b0, w_serial[0]};
        w_e1  = {1'b0, w_serial[1]};
        w_s2  = {1'b0, w_serial[2]};
        w_e2x = {1'b0, w_serial[3]} + DIFF_W'(1);
    end

    always_ff @(posedge i_clk) begin
        r4_lo <= (w_s1 > w_s2) ? w_s1 : w_s2;
        r4_hi <= (w_e1 < w_e2x) ? w_e1 : w_e2x;
        r4_ok <= &w_ok;
    end

    // stage 5: length of the intersection, saturated, zero for a bad date
    always_comb begin
        w_diff      = r4_hi - r4_lo;
        w_diff_wide = WIDE_W'(w_diff);
        w_sat       = (w_diff_wide > WIDE_W'(COUNT_MAX)) ? COUNT_MAX : CNT_W'(w_diff_wide);
        n_days      = (r4_ok && (r4_hi > r4_lo)) ? w_sat : '0;
    end

    always_ff @(posedge i_clk) begin
        r_days <= n_days;
        r_bad  <= !r4_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[2:0], w_accept};
            r_valid <= r_vld[3];
        end
    end

    assign o_valid        = r_valid;
    assign o_overlap_days = r_days;
    assign o_bad_date     = r_bad;

endmodule

`default_nettype wire

// File: rtl/dpodc_checker.sv
`default_nettype none

module dpodc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_start,
    input wire logic                          o_busy,
    input wire logic                          o_valid,
    input wire logic [dpodc_pkg::CNT_W-1:0]   o_overlap_days,
    input wire logic                          o_bad_date
);
    import dpodc_pkg::*;

    logic w_accept;

    assign w_accept = i_start && !o_busy;

    a_beat_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##5 o_valid)
        else $error("accepted beat did not produce a result");

    a_result_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, 5))
        else $error("result without a matching accepted beat");

    a_bad_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_date) |-> (o_overlap_days == '0))
        else $error("bad date with nonzero count");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

endmodule

bind date_period_overlap_day_counter_unit dpodc_checker u_dpodc_checker (.*);

`default_nettype wire

// File: tb/date_period_overlap_day_counter_unit_tb.sv
module date_period_overlap_day_counter_unit_tb;
    import dpodc_pkg::*;

    localparam int P1_START       = 0;
    localparam int P1_END         = 1;
    localparam int P2_START       = 2;
    localparam int P2_END         = 3;
    localparam int RANDOM_BEATS   = 600;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int DIR_ROWS       = 22;
    localparam int COL_TYPED      = 12;
    localparam int COL_DAYS       = 13;
    localparam int COL_BAD        = 14;

    typedef t_date [3:0] period_set_t;

    typedef struct packed {
        logic [CNT_W-1:0] days;
        logic             bad;
    } overlap_res_t;

    // p1 start, p1 end, p2 start, p2 end as day, month, year; then typed flag, days, bad
    int dir_rows [DIR_ROWS][15] = '{
        '{ 1,  1, 2000,   2,  1, 2000,   1,  1, 2000,   1,  1, 2000,   1, 1, 0},
        '{ 1,  1,    1,  31, 12, 9999,   1,  1,    1,  31, 12, 9999,   1, 3652058, 0},
        '{ 1,  1,    1,   2,  1,    1,   1,  1,    1,   1,  1,    1,   1, 1, 0},
        '{30, 12, 9999,  31, 12, 9999,  31, 12, 9999,  31, 12, 9999,   1, 0, 0},
        '{30, 12, 9999,  31, 12, 9999,  30, 12, 9999,  31, 12, 9999,   1, 1, 0},
        '{28,  2, 2000,   1,  3, 2000,  29,  2, 2000,  29,  2, 2000,   1, 1, 0},
        '{ 1,  1, 2023,   1,  1, 2024,   1,  1,    1,  31, 12, 9999,   1, 365, 0},
        '{ 1,  1, 2024,   1,  1, 2025,   1,  1,    1,  31, 12, 9999,   1, 366, 0},
        '{ 1,  3, 2000,   1,  3, 2000,   1,  3, 2000,   1,  3, 2000,   1, 0, 0},
        '{10,  5, 2010,   1,  5, 2010,   1,  1, 2010,  31, 12, 2010,   1, 0, 0},
        '{ 1,  1, 2010,   1,  1, 2011,   1,  6, 2010,  31,  5, 2010,   1, 0, 0},
        '{ 1,  1, 2000,   1,  2, 2000,   1,  1, 2001,  31, 12, 2001,   1, 0, 0},
        '{10,  2, 2024,   5,  3, 2024,  20,  2, 2024,  31, 12, 2024,   0, 0, 0},
        '{31, 12, 1899,   1,  3, 1900,  15,  1, 1900,  28,  2, 1900,   0, 0, 0},
        '{29,  2, 1900,   1,  1, 2000,   1,  1, 1900,   1,  1, 2000,   1, 0, 1},
        '{ 1,  1, 2020,  29,  2, 2023,   1,  1, 2020,   1,  1, 2021,   1, 0, 1},
        '{ 1,  1, 2020,   1,  1, 2021,  31,  4, 2024,   1,  1, 2021,   1, 0, 1},
        '{ 1,  1, 2020,   1,  1, 2021,   1,  1, 2020,   0,  6, 2020,   1, 0, 1},
        '{ 1,  0, 2020,   1,  1, 2021,   1,  1, 2020,   1,  1, 2021,   1, 0, 1},
        '{ 1,  1, 2020,   1, 13, 2021,   1,  1, 2020,   1,  1, 2021,   1, 0, 1},
        '{ 1,  1,    0,   1,  1, 2021,   1,  1, 2020,   1,  1, 10000,  1, 0, 1},
        '{31, 15, 16383, 31, 15, 16383, 31, 15, 16383, 31, 15, 16383,  1, 0, 1}
    };

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    logic [DAY_W-1:0]  i_p1_start_day   = '0;
    logic [MON_W-1:0]  i_p1_start_month = '0;
    logic [YEAR_W-1:0] i_p1_start_year  = '0;
    logic [DAY_W-1:0]  i_p1_end_day     = '0;
    logic [MON_W-1:0]  i_p1_end_month   = '0;
    logic [YEAR_W-1:0] i_p1_end_year    = '0;
    logic [DAY_W-1:0]  i_p2_start_day   = '0;
    logic [MON_W-1:0]  i_p2_start_month = '0;
    logic [YEAR_W-1:0] i_p2_start_year  = '0;
    logic [DAY_W-1:0]  i_p2_end_day     = '0;
    logic [MON_W-1:0]  i_p2_end_month   = '0;
    logic [YEAR_W-1:0] i_p2_end_year    = '0;
    logic              o_valid;
    logic [CNT_W-1:0]  o_overlap_days;
    logic              o_bad_date;

    overlap_res_t pending_overlaps [$];
    int           err_count   = 0;
    int           idle_cycles = 0;
    bit           idle_on     = 1'b1;

    date_period_overlap_day_counter_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_p1_start_day   (i_p1_start_day),
        .i_p1_start_month (i_p1_start_month),
        .i_p1_start_year  (i_p1_start_year),
        .i_p1_end_day     (i_p1_end_day),
        .i_p1_end_month   (i_p1_end_month),
        .i_p1_end_year    (i_p1_end_year),
        .i_p2_start_day   (i_p2_start_day),
        .i_p2_start_month (i_p2_start_month),
        .i_p2_start_year  (i_p2_start_year),
        .i_p2_end_day     (i_p2_end_day),
        .i_p2_end_month   (i_p2_end_month),
        .i_p2_end_year    (i_p2_end_year),
        .o_valid          (o_valid),
        .o_overlap_days   (o_overlap_days),
        .o_bad_date       (o_bad_date)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        bit leap;
        leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit day_serial(input t_date d, output longint serial);
        longint      p;
        int unsigned len;
        serial = 0;
        if (d.year < 1 || d.year > YEAR_MAX_DEF) return 1'b0;
        len = month_days(d.month, d.year);
        if (len == 0 || d.day < 1 || d.day > len) return 1'b0;
        p = longint'(d.year) - 1;
        serial = p * 365 + p / 4 - p / 100 + p / 400 + longint'(d.day);
        for (int k = 1; k < d.month; k++) serial += month_days(k, d.year);
        return 1'b1;
    endfunction

    function automatic overlap_res_t predict_overlap(period_set_t q);
        longint       s [4];
        longint       lo, hi, cnt;
        bit           ok;
        overlap_res_t r;
        ok = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (!day_serial(q[k], s[k])) ok = 1'b0;
        end
        r.days = '0;
        r.bad  = !ok;
        if (ok) begin
            lo  = (s[P1_START] > s[P2_START]) ? s[P1_START] : s[P2_START];
            hi  = (s[P1_END] < s[P2_END] + 1) ? s[P1_END] : s[P2_END] + 1;
            cnt = (hi > lo) ? hi - lo : 0;
            if (cnt > longint'(COUNT_MAX)) cnt = longint'(COUNT_MAX);
            r.days = CNT_W'(cnt);
        end
        return r;
    endfunction

    function automatic t_date rand_date(int unsigned yr_lo, int unsigned yr_hi);
        t_date d;
        d.year  = YEAR_W'($urandom_range(yr_hi, yr_lo));
        d.month = MON_W'($urandom_range(12, 1));
        d.day   = DAY_W'($urandom_range(month_days(d.month, d.year), 1));
        return d;
    endfunction

    function automatic t_date noise_date();
        t_date d;
        d.day   = DAY_W'($urandom_range(31, 0));
        d.month = MON_W'($urandom_range(15, 0));
        d.year  = YEAR_W'($urandom_range(16383, 0));
        return d;
    endfunction

    function automatic period_set_t rand_periods();
        period_set_t q;
        int unsigned kind, base, span, yr_lo, yr_hi;
        kind  = $urandom_range(9, 0);
        base  = $urandom_range(YEAR_MAX_DEF, 1);
        span  = (kind == 2) ? YEAR_MAX_DEF : $urandom_range(3, 0);
        yr_lo = (base > span) ? base - span : 1;
        yr_hi = (base + span < YEAR_MAX_DEF) ? base + span : YEAR_MAX_DEF;
        for (int k = 0; k < 4; k++) begin
            q[k] = (kind == 0) ? noise_date() : rand_date(yr_lo, yr_hi);
        end
        if (kind == 1) q[$urandom_range(3, 0)] = noise_date();
        return q;
    endfunction

    task automatic send_beat(input period_set_t q, input overlap_res_t want);
        int gap;
        gap = idle_on ? $urandom_range(15, 0) : 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start          <= 1'b1;
        i_p1_start_day   <= q[P1_START].day;
        i_p1_start_month <= q[P1_START].month;
        i_p1_start_year  <= q[P1_START].year;
        i_p1_end_day     <= q[P1_END].day;
        i_p1_end_month   <= q[P1_END].month;
        i_p1_end_year    <= q[P1_END].year;
        i_p2_start_day   <= q[P2_START].day;
        i_p2_start_month <= q[P2_START].month;
        i_p2_start_year  <= q[P2_START].year;
        i_p2_end_day     <= q[P2_END].day;
        i_p2_end_month   <= q[P2_END].month;
        i_p2_end_year    <= q[P2_END].year;
        do @(posedge i_clk); while (o_busy);
        pending_overlaps.push_back(want);
    endtask

    initial begin
        period_set_t  q;
        overlap_res_t want;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int k = 0; k < 4; k++) begin
                q[k].day   = DAY_W'(dir_rows[r][3 * k]);
                q[k].month = MON_W'(dir_rows[r][3 * k + 1]);
                q[k].year  = YEAR_W'(dir_rows[r][3 * k + 2]);
            end
            if (dir_rows[r][COL_TYPED] != 0) begin
                want.days = CNT_W'(dir_rows[r][COL_DAYS]);
                want.bad  = dir_rows[r][COL_BAD] != 0;
            end else begin
                want = predict_overlap(q);
            end
            send_beat(q, want);
        end
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 64 == 0) idle_on = $urandom_range(2, 0) != 0;
            q = rand_periods();
            send_beat(q, predict_overlap(q));
        end
        i_start <= 1'b0;
        while (pending_overlaps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("date_period_overlap_day_counter_unit_tb: clean");
        end else begin
            $display("date_period_overlap_day_counter_unit_tb: errors");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        overlap_res_t want;
        if (i_rst_n && o_valid) begin
            if (pending_overlaps.size() == 0) begin
                $error("overlap_days: result %0d with nothing pending", o_overlap_days);
                err_count++;
            end else begin
                want = pending_overlaps.pop_front();
                if (o_overlap_days !== want.days) begin
                    $error("overlap_days: expected %0d, got %0d", want.days, o_overlap_days);
                    err_count++;
                end
                if (o_bad_date !== want.bad) begin
                    $error("bad_date: expected %0b, got %0b", want.bad, o_bad_date);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("date_period_overlap_day_counter_unit_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// File: files.f
rtl/dpodc_pkg.sv
rtl/dpodc_day_num.sv
rtl/date_period_overlap_day_counter_unit.sv
rtl/dpodc_checker.sv
tb/date_period_overlap_day_counter_unit_tb.sv
